>>> rtl/ohtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Owner/handle tracking table package
// Shared sizes, request codes and word types for the tracking table core.
// ----------------------------------------------------------------------------
package ohtt_pkg;

    // Table size and derived index widths.
    localparam int ENTRIES = 128;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_TRACK   = 2'd0,
        REQ_UNTRACK = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Input word.
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] owner_id;
        logic signed [31:0] handle;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic hit;
        logic rejected;
    } t_out_word;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [31:0] owner;
        logic [31:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage : ohtt_pkg
`default_nettype wire

>>> rtl/ohtt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ohtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : ohtt_ram
`default_nettype wire

>>> rtl/owner_handle_tracking_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Owner/handle tracking table core
// Tracks, untracks and queries owner/handle pairs in a table held in RAM.
// ----------------------------------------------------------------------------
// A rejected or unused request goes from accept straight to the done state; a
// valid request scans one entry a cycle until a match or the last entry. Either
// way the word is loaded once the output register is free or being taken. One
// request is in work at a time and the next is taken the cycle after the word
// is loaded, as the scan holds the one read port.
// Reset clears the per-entry valid flags; an entry that is not valid reads as free.
module owner_handle_tracking_table_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ohtt_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ohtt_pkg::t_out_word      o_out_word
);
    import ohtt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    t_in_word         r_req, n_req;
    logic [CNT_W-1:0] r_iss, n_iss;
    logic             r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_chk_vld, n_chk_vld;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic             r_hit, n_hit;
    logic             r_rej, n_rej;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;
    logic [ENTRIES-1:0] r_entry_vld;

    logic             in_accept;
    logic             in_rejected;
    logic [IDX_W-1:0] rd_idx;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    logic             vld_set;
    logic             vld_clr;
    logic [IDX_W-1:0] vld_idx;
    logic             owner_match;
    logic             pair_match;
    logic             chk_last;

    // Entry storage.
    ohtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // Input handshake and operand check.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_rejected = i_in_word.owner_id[31] || (i_in_word.owner_id == 32'sd0)
                         || i_in_word.handle[31];

    // Compare the entry read last cycle; entries not valid read as free.
    assign rd_idx      = r_iss[IDX_W-1:0];
    assign owner_match = r_chk_vld && (ram_rdata.owner == r_req.owner_id);
    assign pair_match  = owner_match && (ram_rdata.handle == r_req.handle);
    assign chk_last    = (r_chk_idx == IDX_W'(ENTRIES - 1));

    // Next-state logic for the scan sequencer.
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_iss        = r_iss;
        n_chk_valid  = 1'b0;
        n_chk_idx    = rd_idx;
        n_chk_vld    = r_entry_vld[rd_idx];
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_rej        = r_rej;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        ram_we       = 1'b0;
        ram_waddr    = r_chk_idx;
        ram_wdata    = '{owner: r_req.owner_id, handle: r_req.handle};
        vld_set      = 1'b0;
        vld_clr      = 1'b0;
        vld_idx      = r_chk_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req        = i_in_word;
                    n_iss        = '0;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    n_rej        = in_rejected;
                    if (in_rejected || (i_in_word.req_type == REQ_NONE)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue one read a cycle until every entry is requested.
                if (r_iss < CNT_W'(ENTRIES)) begin
                    n_chk_valid = 1'b1;
                    n_iss       = r_iss + CNT_W'(1);
                end
                if (r_chk_valid) begin
                    case (t_req'(r_req.req_type))
                        REQ_TRACK: begin
                            if (owner_match) begin
                                ram_we  = 1'b1;
                                vld_set = 1'b1;
                                n_state = S_DONE;
                            end else if (chk_last) begin
                                // No owner match: first free entry, else entry 0.
                                ram_we  = 1'b1;
                                vld_set = 1'b1;
                                if (r_free_found) begin
                                    ram_waddr = r_free_idx;
                                end else if (!r_chk_vld) begin
                                    ram_waddr = r_chk_idx;
                                end else begin
                                    ram_waddr = '0;
                                end
                                vld_idx = ram_waddr;
                                n_state = S_DONE;
                            end else if (!r_chk_vld && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_chk_idx;
                            end
                        end
                        REQ_UNTRACK: begin
                            if (pair_match) begin
                                vld_clr = 1'b1;
                                n_state = S_DONE;
                            end else if (chk_last) begin
                                n_state = S_DONE;
                            end
                        end
                        REQ_QUERY: begin
                            if (pair_match) begin
                                n_hit   = 1'b1;
                                n_state = S_DONE;
                            end else if (chk_last) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                // Load the output register once it is free or being taken.
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{hit: r_hit, rejected: r_rej};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_iss        <= n_iss;
        r_chk_idx    <= n_chk_idx;
        r_chk_vld    <= n_chk_vld;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_hit        <= n_hit;
        r_rej        <= n_rej;
        r_out_word   <= n_out_word;
    end

    // Per-entry valid flags; an entry that is not valid is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
        end else if (vld_set) begin
            r_entry_vld[vld_idx] <= 1'b1;
        end else if (vld_clr) begin
            r_entry_vld[vld_idx] <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule : owner_handle_tracking_table_core
`default_nettype wire

>>> tb/sv/ohtt_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Owner/handle tracking table monitor
// Watches both channels of the tracking table core and keeps its own copy of
// the table. It works out the reply to every accepted request word and checks
// each reply word against the oldest one still waiting.
// ----------------------------------------------------------------------------
module ohtt_monitor (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire ohtt_pkg::t_in_word  i_in_word,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire ohtt_pkg::t_out_word i_out_word,
    output int                       o_fail_count,
    output int                       o_pending
);
    import ohtt_pkg::*;

    // Shadow copy of the table; an owner of zero marks a free slot.
    logic [31:0] shadow_owner  [ENTRIES];
    logic [31:0] shadow_handle [ENTRIES];

    // Replies owed by the core, oldest first.
    t_out_word pending_replies[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Index of the first slot holding exactly this pair, or -1.
    function automatic int find_pair(input logic [31:0] own, input logic [31:0] hnd);
        int hit_idx;
        hit_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_idx < 0 && shadow_owner[i] == own && shadow_handle[i] == hnd) begin
                hit_idx = i;
            end
        end
        return hit_idx;
    endfunction

    // Applies one request to the shadow table and returns the reply it owes.
    function automatic t_out_word apply_request(input t_in_word w);
        t_out_word   reply;
        int          match_idx;
        int          free_idx;
        logic [31:0] own;
        logic [31:0] hnd;
        own            = w.owner_id;
        hnd            = w.handle;
        reply.hit      = 1'b0;
        reply.rejected = (own == 32'd0) || own[31] || hnd[31];
        if (!reply.rejected) begin
            case (t_req'(w.req_type))
                REQ_TRACK: begin
                    // Update the first slot of this owner, else take the
                    // first free slot, else overwrite slot zero.
                    match_idx = -1;
                    free_idx  = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (match_idx < 0 && shadow_owner[i] == own) begin
                            match_idx = i;
                        end
                        if (free_idx < 0 && shadow_owner[i] == 32'd0) begin
                            free_idx = i;
                        end
                    end
                    if (match_idx >= 0) begin
                        shadow_handle[match_idx] = hnd;
                    end else begin
                        if (free_idx < 0) begin
                            free_idx = 0;
                        end
                        shadow_owner[free_idx]  = own;
                        shadow_handle[free_idx] = hnd;
                    end
                end
                REQ_UNTRACK: begin
                    match_idx = find_pair(own, hnd);
                    if (match_idx >= 0) begin
                        shadow_owner[match_idx]  = 32'd0;
                        shadow_handle[match_idx] = 32'd0;
                    end
                end
                REQ_QUERY: begin
                    reply.hit = (find_pair(own, hnd) >= 0);
                end
                default: begin
                    // The unused code changes nothing and never hits.
                end
            endcase
        end
        return reply;
    endfunction

    // Replies are checked before the new request is queued, so a reply never
    // pairs with a request accepted at the same edge.
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                shadow_owner[i]  = 32'd0;
                shadow_handle[i] = 32'd0;
            end
            pending_replies.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply word with none owed: hit %0b rejected %0b",
                             $time, i_out_word.hit, i_out_word.rejected);
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (want.hit !== i_out_word.hit) begin
                        $display("%0t: hit mismatch: expected %0b, actual %0b",
                                 $time, want.hit, i_out_word.hit);
                        o_fail_count++;
                    end
                    if (want.rejected !== i_out_word.rejected) begin
                        $display("%0t: rejected mismatch: expected %0b, actual %0b",
                                 $time, want.rejected, i_out_word.rejected);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies.push_back(apply_request(i_in_word));
            end
            o_pending = pending_replies.size();
        end
    end

endmodule : ohtt_monitor

>>> tb/sv/tb_owner_handle_tracking_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Owner/handle tracking table core testbench
// Drives directed and random track, untrack and query words into the core,
// with random idle and stall bursts and one long output hold-off, and lets the
// monitor check every reply word against its own shadow table.
// ----------------------------------------------------------------------------
module tb_owner_handle_tracking_table_core;
    import ohtt_pkg::*;

    localparam int RANDOM_WORDS = 1620;
    localparam int PHASE_WORDS  = RANDOM_WORDS / 6;
    localparam int HOLD_AT      = 420;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    int fail_count;
    int pending;
    int words_sent;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_done;

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    owner_handle_tracking_table_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    ohtt_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one word from a falling edge and holds it until accepted; returns
    // at the falling edge after acceptance.
    task automatic push_word(input t_in_word w);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_req(input t_req req, input logic [31:0] own,
                            input logic [31:0] hnd);
        t_in_word w;
        w.req_type = req;
        w.owner_id = own;
        w.handle   = hnd;
        push_word(w);
    endtask

    // Builds one random word: mostly well-formed requests over a pool of
    // owners and handles, the rest random noise with bad operands or the
    // unused code.
    function automatic t_in_word make_request(input int owner_pool, input int handle_span,
                                              input bit high_vals, input int pct_track,
                                              input int pct_untrack, input int pct_query);
        t_in_word    w;
        int          roll;
        logic [31:0] own;
        logic [31:0] hnd;
        roll = $urandom_range(0, 99);
        own  = high_vals ? 32'h7fff_ffff - 32'($urandom_range(0, owner_pool - 1))
                         : 32'($urandom_range(1, owner_pool));
        hnd  = high_vals ? 32'h7fff_ffff - 32'($urandom_range(0, handle_span))
                         : 32'($urandom_range(0, handle_span));
        w.owner_id = own;
        w.handle   = hnd;
        if (roll < pct_track) begin
            w.req_type = REQ_TRACK;
        end else if (roll < pct_track + pct_untrack) begin
            w.req_type = REQ_UNTRACK;
        end else if (roll < pct_track + pct_untrack + pct_query) begin
            w.req_type = REQ_QUERY;
        end else begin
            w.req_type = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: w.handle   = $urandom;
                1: w.owner_id = $urandom;
                default: begin
                    w.owner_id = $urandom;
                    w.handle   = $urandom;
                end
            endcase
        end
        return w;
    endfunction

    // Output side: one long hold-off once the run is under way, otherwise
    // random stall bursts while idling is enabled.
    initial begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        in_valid   = 1'b0;
        in_word    = '0;
        i_rst_n    = 1'b0;
        words_sent = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty-table miss, update of an owner, pair-exact
        // untrack, extreme operands, rejected words and the unused code.
        send_req(REQ_QUERY,   32'd1,         32'd0);
        send_req(REQ_TRACK,   32'd1,         32'd0);
        send_req(REQ_QUERY,   32'd1,         32'd0);
        send_req(REQ_TRACK,   32'd1,         32'd5);
        send_req(REQ_QUERY,   32'd1,         32'd0);
        send_req(REQ_QUERY,   32'd1,         32'd5);
        send_req(REQ_UNTRACK, 32'd1,         32'd0);
        send_req(REQ_UNTRACK, 32'd1,         32'd5);
        send_req(REQ_QUERY,   32'd1,         32'd5);
        send_req(REQ_TRACK,   32'h7fff_ffff, 32'h7fff_ffff);
        send_req(REQ_QUERY,   32'h7fff_ffff, 32'h7fff_ffff);
        send_req(REQ_TRACK,   32'd0,         32'd3);
        send_req(REQ_QUERY,   32'd0,         32'd0);
        send_req(REQ_TRACK,   32'hffff_ffff, 32'd3);
        send_req(REQ_TRACK,   32'h8000_0000, 32'd0);
        send_req(REQ_TRACK,   32'd7,         32'hffff_ffff);
        send_req(REQ_QUERY,   32'd7,         32'h8000_0000);
        send_req(REQ_NONE,    32'd7,         32'd7);
        send_req(REQ_NONE,    32'd0,         32'hffff_ffff);
        send_req(REQ_TRACK,   32'd2,         32'd3);
        send_req(REQ_NONE,    32'd2,         32'd3);
        send_req(REQ_UNTRACK, 32'h7fff_ffff, 32'h7fff_ffff);
        send_req(REQ_QUERY,   32'h7fff_ffff, 32'h7fff_ffff);
        send_req(REQ_UNTRACK, 32'hffff_fffb, 32'd3);
        send_req(REQ_QUERY,   32'd2,         32'd3);

        // Random part in phases: a small pool for frequent hits, a wide pool
        // with heavy tracking to fill the table and overwrite slot zero, high
        // operand values, and a final phase without idling.
        for (int phase = 0; phase < 6; phase++) begin
            for (int n = 0; n < PHASE_WORDS; n++) begin
                case (phase)
                    0: push_word(make_request(8,   3, 1'b0, 40, 20, 30));
                    1: push_word(make_request(200, 1, 1'b0, 75, 5,  15));
                    2: push_word(make_request(200, 1, 1'b0, 20, 20, 50));
                    3: push_word(make_request(40,  3, 1'b1, 40, 20, 30));
                    4: push_word(make_request(300, 2, 1'b0, 45, 15, 30));
                    default: push_word(make_request(8, 3, 1'b0, 35, 25, 30));
                endcase
            end
            case (phase)
                1: begin
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                2: begin
                    tx_idle_on = 1'b1;
                    rx_idle_on = 1'b1;
                end
                4: begin
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                default: begin
                end
            endcase
        end
        in_valid <= 1'b0;

        // Drain the replies still owed, then give the core time to show any
        // stray reply word.
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS owner_handle_tracking_table_core");
        end else begin
            $display("FAIL owner_handle_tracking_table_core");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #10_000_000;
        $display("FAIL owner_handle_tracking_table_core");
        $finish;
    end

endmodule : tb_owner_handle_tracking_table_core

>>> files.f
rtl/ohtt_pkg.sv
rtl/ohtt_ram.sv
rtl/owner_handle_tracking_table_core.sv
tb/sv/ohtt_monitor.sv
tb/sv/tb_owner_handle_tracking_table_core.sv
